### design/tournament_tree_min_update_top_macros.svh
// Assertion macros for the tournament tree minimum block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TOURNAMENT_TREE_MIN_UPDATE_TOP_MACROS_SVH
`define TOURNAMENT_TREE_MIN_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tournament tree check failed");
`define TTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tournament tree check failed");
`else
`define TTM_ASSERT_IMP(lbl, ante, cons)
`define TTM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/ttm_pkg.sv
// Shared types and constants for the tournament tree minimum block.
// No dependencies.
`default_nettype none
package ttm_pkg;

  localparam int LEAF_COUNT_DEF = 16;
  localparam int VALUE_W = 32;
  localparam logic signed [VALUE_W-1:0] RESET_VALUE = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } ttm_state_t;

  typedef struct packed {
    logic clr;
    logic start;
    logic step;
    logic load_out;
  } ttm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic root_done;
  } ttm_status_t;

endpackage
`default_nettype wire

### design/ttm_dp.sv
// Datapath: leaf and winner memories, walk registers and result register.
// Depends on ttm_pkg; driven by ttm_ctrl through command and status structs.
`default_nettype none
module ttm_dp #(
  parameter int LEAF_COUNT = ttm_pkg::LEAF_COUNT_DEF,
  localparam int IDX_W = $clog2(LEAF_COUNT)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ttm_pkg::ttm_cmd_t                     cmd,
  output ttm_pkg::ttm_status_t                       status,
  input  wire logic [IDX_W-1:0]                      in_leaf_index,
  input  wire logic signed [ttm_pkg::VALUE_W-1:0]    in_new_value,
  output logic signed [ttm_pkg::VALUE_W-1:0]         out_minimum_value
);
  import ttm_pkg::*;

  logic signed [VALUE_W-1:0] leaf_mem [LEAF_COUNT];
  logic signed [VALUE_W-1:0] win_mem [LEAF_COUNT];
  logic signed [VALUE_W-1:0] leaf_rd_r;
  logic signed [VALUE_W-1:0] win_rd_r;

  logic [IDX_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W:0]            pos_r, pos_nxt;
  logic signed [VALUE_W-1:0] cur_r, cur_nxt;
  logic                      first_r, first_nxt;
  logic signed [VALUE_W-1:0] out_r;

  logic [IDX_W:0]            parent;
  logic signed [VALUE_W-1:0] sib, left_v, right_v, win_v;

  logic                      leaf_we, win_we;
  logic [IDX_W-1:0]          leaf_wa, leaf_ra, win_wa, win_ra;
  logic signed [VALUE_W-1:0] leaf_wd, win_wd;

  assign parent  = pos_r >> 1;
  assign sib     = first_r ? leaf_rd_r : win_rd_r;
  assign left_v  = pos_r[0] ? sib : cur_r;
  assign right_v = pos_r[0] ? cur_r : sib;
  // On a tie the right child wins.
  assign win_v   = (left_v < right_v) ? left_v : right_v;

  assign status.clr_last  = (clr_cnt_r == IDX_W'(LEAF_COUNT - 1));
  assign status.root_done = (parent == (IDX_W+1)'(1));

  assign leaf_we = cmd.clr | cmd.start;
  assign leaf_wa = cmd.clr ? clr_cnt_r : in_leaf_index;
  assign leaf_wd = cmd.clr ? RESET_VALUE : in_new_value;
  assign leaf_ra = in_leaf_index ^ IDX_W'(1);

  assign win_we = cmd.clr | cmd.step;
  assign win_wa = cmd.clr ? clr_cnt_r : parent[IDX_W-1:0];
  assign win_wd = cmd.clr ? RESET_VALUE : win_v;
  assign win_ra = parent[IDX_W-1:0] ^ IDX_W'(1);

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[leaf_wa] <= leaf_wd;
    end
    leaf_rd_r <= leaf_mem[leaf_ra];
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_wa] <= win_wd;
    end
    win_rd_r <= win_mem[win_ra];
  end

  always_comb begin
    clr_cnt_nxt = cmd.clr ? clr_cnt_r + IDX_W'(1) : clr_cnt_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    first_nxt   = first_r;
    if (cmd.start) begin
      pos_nxt   = {1'b1, in_leaf_index};
      cur_nxt   = in_new_value;
      first_nxt = 1'b1;
    end else if (cmd.step) begin
      pos_nxt   = parent;
      cur_nxt   = win_v;
      first_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      first_r   <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      first_r   <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cur_r <= cur_nxt;
    if (cmd.load_out) begin
      out_r <= cmd.step ? win_v : cur_r;
    end
  end

  assign out_minimum_value = out_r;

endmodule
`default_nettype wire

### design/ttm_ctrl.sv
// Controller: clearing pass, tree walk sequencing and output handshake.
// Depends on ttm_pkg; commands ttm_dp through command and status structs.
`default_nettype none
module ttm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ttm_pkg::ttm_cmd_t         cmd,
  input  wire ttm_pkg::ttm_status_t status
);
  import ttm_pkg::*;

  ttm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (status.root_done) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        cmd.start = in_valid;
      end
      ST_WALK: begin
        cmd.step     = 1'b1;
        cmd.load_out = status.root_done & out_free;
      end
      ST_HOLD: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### design/tournament_tree_min_update_top.sv
// Tournament tree minimum: each input beat writes one leaf and walks the
// tree to the root; each beat yields one output beat with the new minimum.
// Input beat: in_leaf_index selects the leaf, in_new_value is its signed value.
// Output beat: out_minimum_value is the smallest leaf value after the update.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// Each item first writes the leaf and reads its sibling, then at each tree
// level computes a winner, writes it and reads the next sibling from the
// winner memory. When the output register is free, the result is valid in
// the cycle after the root is computed.
// One item is in the tree at a time; the next input beat is taken as soon as
// the walk ends, even while the previous result waits on out_stall.
// If out_stall holds a result when the next walk ends, the block waits with
// in_stall high until the output register frees up.
// After reset a clearing pass writes every leaf and winner address in turn
// with the largest signed value; in_stall is high during that pass.
// Depends on ttm_pkg, ttm_ctrl, ttm_dp and the assertion macro header.
`default_nettype none
`include "tournament_tree_min_update_top_macros.svh"
module tournament_tree_min_update_top #(
  parameter int LEAF_COUNT = ttm_pkg::LEAF_COUNT_DEF,
  localparam int IDX_W = $clog2(LEAF_COUNT)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [IDX_W-1:0]                    in_leaf_index,
  input  wire logic signed [ttm_pkg::VALUE_W-1:0]  in_new_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ttm_pkg::VALUE_W-1:0]       out_minimum_value
);
  import ttm_pkg::*;

  ttm_cmd_t    cmd;
  ttm_status_t status;

  ttm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ttm_dp #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_leaf_index     (in_leaf_index),
    .in_new_value      (in_new_value),
    .out_minimum_value (out_minimum_value)
  );

  `TTM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `TTM_ASSERT_IMP(a_no_result_while_clearing, cmd.clr, !out_valid)
  `TTM_ASSERT_IMP(a_result_from_walk, $rose(out_valid), $past(cmd.load_out))

endmodule
`default_nettype wire

### dv/tb_tournament_tree_min_update_top.sv
// Testbench for tournament_tree_min_update_top: leaf updates are predicted by a
// behavioral copy of the winner tree, and every output beat is checked in order.
// Depends on ttm_pkg and the block under test; uses no files or arguments.
`default_nettype none
module tb_tournament_tree_min_update_top;

  localparam int LEAVES = ttm_pkg::LEAF_COUNT_DEF;
  localparam int IDX_W = $clog2(LEAVES);
  localparam int VW = ttm_pkg::VALUE_W;
  localparam logic signed [VW-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [VW-1:0] MIN_VAL = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_leaf_index = '0;
  logic signed [VW-1:0] in_new_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] out_minimum_value;

  tournament_tree_min_update_top #(.LEAF_COUNT(LEAVES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_leaf_index(in_leaf_index),
    .in_new_value(in_new_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_minimum_value(out_minimum_value)
  );

  always #1 clk = ~clk;

  logic signed [VW-1:0] leaf_copy [LEAVES];
  logic signed [VW-1:0] winner_copy [LEAVES];
  logic signed [VW-1:0] pending_minimums [$];

  int updates_sent = 0;
  int minimums_seen = 0;
  int failures = 0;
  int cycle_count = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_len = 0;
  int hold_left = 0;
  int run_left = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [VW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return MIN_VAL;
      1: return MAX_VAL;
      2, 3: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic signed [VW-1:0] apply_update(input logic [IDX_W-1:0] idx,
                                                       input logic signed [VW-1:0] val);
    int node;
    logic signed [VW-1:0] lval, rval;
    leaf_copy[idx] = val;
    node = (int'(idx) + LEAVES) >> 1;
    while (node != 0) begin
      if (2 * node >= LEAVES) begin
        lval = leaf_copy[IDX_W'(2 * node - LEAVES)];
        rval = leaf_copy[IDX_W'(2 * node + 1 - LEAVES)];
      end else begin
        lval = winner_copy[IDX_W'(2 * node)];
        rval = winner_copy[IDX_W'(2 * node + 1)];
      end
      winner_copy[IDX_W'(node)] = (lval < rval) ? lval : rval;
      node = node >> 1;
    end
    return winner_copy[IDX_W'(1)];
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  task automatic send_leaf(input logic [IDX_W-1:0] idx, input logic signed [VW-1:0] val);
    int gap;
    in_valid <= 1'b1;
    in_leaf_index <= idx;
    in_new_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_minimums.push_back(apply_update(idx, val));
    updates_sent++;
    gap = tx_idle_on ? rand_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_minimums.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_leaf(4'd15, MAX_VAL);
    send_leaf(4'd0, MIN_VAL);
    send_leaf(4'd15, MIN_VAL);
    send_leaf(4'd0, MAX_VAL);
    send_leaf(4'd15, MAX_VAL);
    send_leaf(4'd6, -32'sd5);
    send_leaf(4'd7, -32'sd5);
    send_leaf(4'd7, 32'sd3);
    send_leaf(4'd6, 32'sd3);
    send_leaf(4'd9, 32'sd0);
    send_leaf(4'd10, -32'sd1);
    send_leaf(4'd5, 32'sd1);
    send_leaf(4'd10, MAX_VAL);
    send_leaf(4'd3, MIN_VAL + 1);
    send_leaf(4'd12, MAX_VAL - 1);
    send_leaf(4'd3, MAX_VAL);
    send_leaf(4'd8, 32'sh5555_5555);
    send_leaf(4'd1, 32'shAAAA_AAAA);
    send_leaf(4'd1, MAX_VAL);
    send_leaf(4'd14, 32'sd0);
  endtask

  task automatic test_random_updates(input int count);
    repeat (count) send_leaf(IDX_W'($urandom), pick_value());
  endtask

  task automatic test_output_hold_off();
    tx_idle_on = 1'b0;
    hold_len = 300;
    hold_req++;
    repeat (12) send_leaf(IDX_W'($urandom), pick_value());
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_between_bursts();
    repeat (4) begin
      test_random_updates($urandom_range(3, 8));
      wait_drained();
    end
  endtask

  task automatic test_full_rate_burst();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_updates(150);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_sweep_all_leaves();
    int i;
    for (i = 0; i < LEAVES; i++) send_leaf(IDX_W'(i), MIN_VAL + i);
    for (i = 0; i < LEAVES; i++) send_leaf(IDX_W'(i), MAX_VAL);
  endtask

  always @(posedge clk) begin : rx_pacing
    int gap;
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!rx_idle_on) begin
      out_stall <= 1'b0;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      gap = rand_gap();
      if (!out_stall && gap > 0) begin
        out_stall <= 1'b1;
        run_left <= gap - 1;
      end else begin
        out_stall <= 1'b0;
        run_left <= $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic signed [VW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      minimums_seen++;
      if (pending_minimums.size() == 0) begin
        note_failure($sformatf("unexpected output beat: minimum %0d", out_minimum_value));
      end else begin
        want = pending_minimums.pop_front();
        if (out_minimum_value !== want)
          note_failure($sformatf("minimum mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                                 want, want, out_minimum_value, out_minimum_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_minimums.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < LEAVES; i++) begin
      leaf_copy[IDX_W'(i)] = ttm_pkg::RESET_VALUE;
      winner_copy[IDX_W'(i)] = ttm_pkg::RESET_VALUE;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_sweep_all_leaves();
    test_output_hold_off();
    test_drain_between_bursts();
    test_full_rate_burst();
    test_random_updates(850);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_minimums.size() != 0)
      note_failure($sformatf("%0d expected minimums never arrived", pending_minimums.size()));
    $display("Sent %0d leaf updates and checked %0d minimum beats, including extremes, ties,",
             updates_sent, minimums_seen);
    $display("a full leaf sweep, a long output hold-off, drained bursts and a full-rate run.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", failures);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+design
design/ttm_pkg.sv
design/ttm_dp.sv
design/ttm_ctrl.sv
design/tournament_tree_min_update_top.sv
dv/tb_tournament_tree_min_update_top.sv
